// ===== rtl/tlbl_pkg.sv =====
// Package with shared constants and types for the LRU translation buffer.
`timescale 1ns / 1ps
package tlbl_pkg;

    localparam int PAGE_W = 20;
    localparam int FRAME_W = 8;
    localparam int COUNT_W = 32;
    localparam int CFG_W = 32;
    localparam int MASK_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int TABLE_PAGES = 8;
    localparam int TLB_ENTRIES_DEFAULT = 8;

    localparam logic [CFG_W-1:0] FRAMES_LOW_RESET = 32'h0108_0205;
    localparam logic [CFG_W-1:0] FRAMES_HIGH_RESET = 32'h0407_0309;
    localparam logic [MASK_W-1:0] VALID_MASK_RESET = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_MASK = 2'd2;

    typedef enum logic [1:0] {
        OUT_TLB_HIT = 2'd0,
        OUT_FILL    = 2'd1,
        OUT_FAULT   = 2'd2
    } outcome_t;

    typedef struct packed {
        logic               hit;
        logic               free;
        logic [FRAME_W-1:0] hit_frame;
        logic [PAGE_W-1:0]  lru_page;
    } carry_t;

    typedef struct packed {
        logic               en;
        logic               fill;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } upd_t;

endpackage

// ===== rtl/tlbl_cell.sv =====
// One buffer entry that checks the passing search token and applies updates.
`timescale 1ns / 1ps
module tlbl_cell #(
    parameter int TLB_ENTRIES = tlbl_pkg::TLB_ENTRIES_DEFAULT,
    parameter int IDX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [tlbl_pkg::PAGE_W-1:0]         key,
    input  logic                                in_valid,
    input  tlbl_pkg::carry_t                    in_carry,
    input  logic [$clog2(TLB_ENTRIES)-1:0]      in_hit_idx,
    input  logic [$clog2(TLB_ENTRIES)-1:0]      in_hit_rank,
    input  logic [$clog2(TLB_ENTRIES)-1:0]      in_free_idx,
    input  logic [$clog2(TLB_ENTRIES)-1:0]      in_free_rank,
    input  logic [$clog2(TLB_ENTRIES)-1:0]      in_lru_idx,
    input  tlbl_pkg::upd_t                      upd,
    input  logic [$clog2(TLB_ENTRIES)-1:0]      upd_idx,
    input  logic [$clog2(TLB_ENTRIES)-1:0]      upd_rank,
    output logic                                out_valid,
    output tlbl_pkg::carry_t                    out_carry,
    output logic [$clog2(TLB_ENTRIES)-1:0]      out_hit_idx,
    output logic [$clog2(TLB_ENTRIES)-1:0]      out_hit_rank,
    output logic [$clog2(TLB_ENTRIES)-1:0]      out_free_idx,
    output logic [$clog2(TLB_ENTRIES)-1:0]      out_free_rank,
    output logic [$clog2(TLB_ENTRIES)-1:0]      out_lru_idx
);
    import tlbl_pkg::*;

    localparam int IDX_W = $clog2(TLB_ENTRIES);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [IDX_W-1:0] LRU_RANK = IDX_W'(TLB_ENTRIES - 1);

    logic               valid_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [IDX_W-1:0]   rank_reg;
    logic [IDX_W-1:0]   rank_next;
    logic               out_valid_reg;
    carry_t             carry_reg;
    carry_t             carry_next;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [IDX_W-1:0]   hit_idx_next;
    logic [IDX_W-1:0]   hit_rank_reg;
    logic [IDX_W-1:0]   hit_rank_next;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [IDX_W-1:0]   free_idx_next;
    logic [IDX_W-1:0]   free_rank_reg;
    logic [IDX_W-1:0]   free_rank_next;
    logic [IDX_W-1:0]   lru_idx_reg;
    logic [IDX_W-1:0]   lru_idx_next;
    logic               write_entry;

    always_comb
    begin
        carry_next = in_carry;
        hit_idx_next = in_hit_idx;
        hit_rank_next = in_hit_rank;
        free_idx_next = in_free_idx;
        free_rank_next = in_free_rank;
        lru_idx_next = in_lru_idx;
        if (valid_reg && (page_reg == key) && !in_carry.hit)
        begin
            carry_next.hit = 1'b1;
            carry_next.hit_frame = frame_reg;
            hit_idx_next = MY_IDX;
            hit_rank_next = rank_reg;
        end
        if (!valid_reg && !in_carry.free)
        begin
            carry_next.free = 1'b1;
            free_idx_next = MY_IDX;
            free_rank_next = rank_reg;
        end
        if (rank_reg == LRU_RANK)
        begin
            carry_next.lru_page = page_reg;
            lru_idx_next = MY_IDX;
        end
    end

    always_comb
    begin
        rank_next = rank_reg;
        if (upd.en)
        begin
            if (upd_idx == MY_IDX)
            begin
                rank_next = '0;
            end
            else if (rank_reg < upd_rank)
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    assign write_entry = upd.en && upd.fill && (upd_idx == MY_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg <= MY_IDX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rank_reg <= rank_next;
            out_valid_reg <= in_valid;
            if (write_entry)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_entry)
        begin
            page_reg <= upd.page;
            frame_reg <= upd.frame;
        end
        carry_reg <= carry_next;
        hit_idx_reg <= hit_idx_next;
        hit_rank_reg <= hit_rank_next;
        free_idx_reg <= free_idx_next;
        free_rank_reg <= free_rank_next;
        lru_idx_reg <= lru_idx_next;
    end

    assign out_valid = out_valid_reg;
    assign out_carry = carry_reg;
    assign out_hit_idx = hit_idx_reg;
    assign out_hit_rank = hit_rank_reg;
    assign out_free_idx = free_idx_reg;
    assign out_free_rank = free_rank_reg;
    assign out_lru_idx = lru_idx_reg;

endmodule

// ===== rtl/tlb_lru_translate_core.sv =====
// Top level of the LRU translation buffer with its page table and counters.
//
// One page number is taken per item and produces exactly one result, strobed
// on done for a single cycle; the receiver cannot stall, so the result must
// be captured in that cycle. A search token walks the row of entry cells one
// cell per clock, from the seed register through each cell register to the
// done register; a new item can be started in the done cycle, not before.
// Configuration writes take effect at once.
`timescale 1ns / 1ps
module tlb_lru_translate_core #(
    parameter int TLB_ENTRIES = tlbl_pkg::TLB_ENTRIES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tlbl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlbl_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [tlbl_pkg::PAGE_W-1:0]       page,
    output logic                              done,
    output logic [tlbl_pkg::FRAME_W-1:0]      frame,
    output tlbl_pkg::outcome_t                outcome,
    output logic                              evicted,
    output logic [tlbl_pkg::PAGE_W-1:0]       evicted_page,
    output logic [tlbl_pkg::COUNT_W-1:0]      hit_total,
    output logic [tlbl_pkg::COUNT_W-1:0]      miss_total
);
    import tlbl_pkg::*;

    localparam int IDX_W = $clog2(TLB_ENTRIES);
    localparam logic [IDX_W-1:0] LRU_RANK = IDX_W'(TLB_ENTRIES - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic [CFG_W-1:0]   frames_low_reg;
    logic [CFG_W-1:0]   frames_high_reg;
    logic [MASK_W-1:0]  valid_mask_reg;
    logic               busy_reg;
    logic               seed_valid_reg;
    logic [PAGE_W-1:0]  key_reg;
    logic               done_reg;
    logic [FRAME_W-1:0] frame_reg;
    outcome_t           outcome_reg;
    logic               evicted_reg;
    logic [PAGE_W-1:0]  evicted_page_reg;
    logic [COUNT_W-1:0] hit_count_reg;
    logic [COUNT_W-1:0] miss_count_reg;

    logic               accept;
    logic               finish;
    logic               mapped;
    logic [CFG_W-1:0]   table_word;
    logic [FRAME_W-1:0] table_frame;
    upd_t               upd;
    logic [IDX_W-1:0]   upd_idx;
    logic [IDX_W-1:0]   upd_rank;

    logic               chain_valid [TLB_ENTRIES+1];
    carry_t             chain_carry [TLB_ENTRIES+1];
    logic [IDX_W-1:0]   chain_hit_idx [TLB_ENTRIES+1];
    logic [IDX_W-1:0]   chain_hit_rank [TLB_ENTRIES+1];
    logic [IDX_W-1:0]   chain_free_idx [TLB_ENTRIES+1];
    logic [IDX_W-1:0]   chain_free_rank [TLB_ENTRIES+1];
    logic [IDX_W-1:0]   chain_lru_idx [TLB_ENTRIES+1];

    assign accept = start && !busy_reg;

    assign chain_valid[0] = seed_valid_reg;
    assign chain_carry[0] = '0;
    assign chain_hit_idx[0] = '0;
    assign chain_hit_rank[0] = '0;
    assign chain_free_idx[0] = '0;
    assign chain_free_rank[0] = '0;
    assign chain_lru_idx[0] = '0;

    for (genvar i = 0; i < TLB_ENTRIES; i++)
    begin : g_cell
        tlbl_cell #(
            .TLB_ENTRIES (TLB_ENTRIES),
            .IDX         (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .key           (key_reg),
            .in_valid      (chain_valid[i]),
            .in_carry      (chain_carry[i]),
            .in_hit_idx    (chain_hit_idx[i]),
            .in_hit_rank   (chain_hit_rank[i]),
            .in_free_idx   (chain_free_idx[i]),
            .in_free_rank  (chain_free_rank[i]),
            .in_lru_idx    (chain_lru_idx[i]),
            .upd           (upd),
            .upd_idx       (upd_idx),
            .upd_rank      (upd_rank),
            .out_valid     (chain_valid[i+1]),
            .out_carry     (chain_carry[i+1]),
            .out_hit_idx   (chain_hit_idx[i+1]),
            .out_hit_rank  (chain_hit_rank[i+1]),
            .out_free_idx  (chain_free_idx[i+1]),
            .out_free_rank (chain_free_rank[i+1]),
            .out_lru_idx   (chain_lru_idx[i+1])
        );
    end

    assign finish = chain_valid[TLB_ENTRIES];
    assign mapped = (key_reg < PAGE_W'(TABLE_PAGES)) && valid_mask_reg[key_reg[2:0]];
    assign table_word = key_reg[2] ? frames_high_reg : frames_low_reg;
    assign table_frame = table_word[{key_reg[1:0], 3'b000} +: FRAME_W];

    always_comb
    begin
        upd.en = 1'b0;
        upd.fill = 1'b0;
        upd.page = key_reg;
        upd.frame = table_frame;
        upd_idx = chain_hit_idx[TLB_ENTRIES];
        upd_rank = chain_hit_rank[TLB_ENTRIES];
        if (finish)
        begin
            if (chain_carry[TLB_ENTRIES].hit)
            begin
                upd.en = 1'b1;
            end
            else if (mapped)
            begin
                upd.en = 1'b1;
                upd.fill = 1'b1;
                if (chain_carry[TLB_ENTRIES].free)
                begin
                    upd_idx = chain_free_idx[TLB_ENTRIES];
                    upd_rank = chain_free_rank[TLB_ENTRIES];
                end
                else
                begin
                    upd_idx = chain_lru_idx[TLB_ENTRIES];
                    upd_rank = LRU_RANK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_low_reg <= FRAMES_LOW_RESET;
            frames_high_reg <= FRAMES_HIGH_RESET;
            valid_mask_reg <= VALID_MASK_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAMES_LOW:  frames_low_reg <= cfg_data;
                REG_FRAMES_HIGH: frames_high_reg <= cfg_data;
                REG_VALID_MASK:  valid_mask_reg <= cfg_data[MASK_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            seed_valid_reg <= 1'b0;
            done_reg <= 1'b0;
            hit_count_reg <= '0;
            miss_count_reg <= '0;
        end
        else
        begin
            seed_valid_reg <= accept;
            done_reg <= finish;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            if (finish)
            begin
                if (chain_carry[TLB_ENTRIES].hit)
                begin
                    if (hit_count_reg != COUNT_MAX)
                    begin
                        hit_count_reg <= hit_count_reg + 1'b1;
                    end
                end
                else if (miss_count_reg != COUNT_MAX)
                begin
                    miss_count_reg <= miss_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= page;
        end
        if (finish)
        begin
            evicted_reg <= 1'b0;
            evicted_page_reg <= '0;
            if (chain_carry[TLB_ENTRIES].hit)
            begin
                frame_reg <= chain_carry[TLB_ENTRIES].hit_frame;
                outcome_reg <= OUT_TLB_HIT;
            end
            else if (mapped)
            begin
                frame_reg <= table_frame;
                outcome_reg <= OUT_FILL;
                if (!chain_carry[TLB_ENTRIES].free)
                begin
                    evicted_reg <= 1'b1;
                    evicted_page_reg <= chain_carry[TLB_ENTRIES].lru_page;
                end
            end
            else
            begin
                frame_reg <= '0;
                outcome_reg <= OUT_FAULT;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign frame = frame_reg;
    assign outcome = outcome_reg;
    assign evicted = evicted_reg;
    assign evicted_page = evicted_page_reg;
    assign hit_total = hit_count_reg;
    assign miss_total = miss_count_reg;

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted item did not raise busy");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result strobed while still busy");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (outcome_reg != OUT_FILL) |-> !evicted_reg)
        else $error("eviction reported without a fill");

    a_counts_move_once: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> ($stable(hit_count_reg) || $stable(miss_count_reg)))
        else $error("both counters moved for one item");

    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> !seed_valid_reg && !accept)
        else $error("second item entered the cell row");

endmodule

// ===== verif/tlb_lru_translate_core_tb.sv =====
// Self-checking testbench for the LRU translation buffer, with directed and random lookups.
`timescale 1ns / 1ps
module tlb_lru_translate_core_tb;
    import tlbl_pkg::*;

    localparam int SLOTS = TLB_ENTRIES_DEFAULT;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS = 200;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS = 500;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [FRAME_W-1:0] frame;
        outcome_t           outcome;
        logic               evicted;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] misses;
    } xlat_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [PAGE_W-1:0]    page = '0;
    logic                 done;
    logic [FRAME_W-1:0]   frame;
    outcome_t             outcome;
    logic                 evicted;
    logic [PAGE_W-1:0]    evicted_page;
    logic [COUNT_W-1:0]   hit_total;
    logic [COUNT_W-1:0]   miss_total;

    // Translation state kept alongside the block.
    logic                 slot_valid [SLOTS];
    logic [PAGE_W-1:0]    slot_page [SLOTS];
    logic [FRAME_W-1:0]   slot_frame [SLOTS];
    int                   slot_age [SLOTS];
    logic [COUNT_W-1:0]   hit_cnt = '0;
    logic [COUNT_W-1:0]   miss_cnt = '0;
    logic [CFG_W-1:0]     pt_low = FRAMES_LOW_RESET;
    logic [CFG_W-1:0]     pt_high = FRAMES_HIGH_RESET;
    logic [MASK_W-1:0]    pt_mask = VALID_MASK_RESET;

    xlat_result_t         pending_xlat [$];
    int                   mismatch_count = 0;
    int                   idle_cycles = 0;
    int                   n_items = 0;
    int                   n_checked = 0;
    int                   n_hits = 0;
    int                   n_fills = 0;
    int                   n_evictions = 0;
    int                   n_faults = 0;
    int                   n_writes = 0;
    bit                   eager = 1'b0;

    tlb_lru_translate_core #(
        .TLB_ENTRIES(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start),
        .busy(busy),
        .page(page),
        .done(done),
        .frame(frame),
        .outcome(outcome),
        .evicted(evicted),
        .evicted_page(evicted_page),
        .hit_total(hit_total),
        .miss_total(miss_total)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        end
    endtask

    function automatic void make_newest(input int e);
        int old_age;
        int i;
        old_age = slot_age[e];
        for (i = 0; i < SLOTS; i++)
        begin
            if (slot_age[i] < old_age)
            begin
                slot_age[i]++;
            end
        end
        slot_age[e] = 0;
    endfunction

    function automatic xlat_result_t translate_page(input logic [PAGE_W-1:0] pg);
        xlat_result_t res;
        int hit_slot;
        int fill_slot;
        int lane;
        int i;
        res.frame = '0;
        res.outcome = OUT_FAULT;
        res.evicted = 1'b0;
        res.evicted_page = '0;
        hit_slot = -1;
        fill_slot = -1;
        lane = int'(pg[1:0]);
        for (i = 0; i < SLOTS; i++)
        begin
            if (hit_slot < 0 && slot_valid[i] && slot_page[i] == pg)
            begin
                hit_slot = i;
            end
        end
        if (hit_slot >= 0)
        begin
            if (hit_cnt != '1)
            begin
                hit_cnt++;
            end
            res.frame = slot_frame[hit_slot];
            res.outcome = OUT_TLB_HIT;
            make_newest(hit_slot);
        end
        else
        begin
            if (miss_cnt != '1)
            begin
                miss_cnt++;
            end
            if (pg < TABLE_PAGES && pt_mask[pg[2:0]])
            begin
                res.frame = (pg < 4) ? pt_low[lane*8 +: FRAME_W] : pt_high[lane*8 +: FRAME_W];
                for (i = 0; i < SLOTS; i++)
                begin
                    if (fill_slot < 0 && !slot_valid[i])
                    begin
                        fill_slot = i;
                    end
                end
                if (fill_slot < 0)
                begin
                    fill_slot = 0;
                    for (i = 0; i < SLOTS; i++)
                    begin
                        if (slot_age[i] == SLOTS - 1)
                        begin
                            fill_slot = i;
                        end
                    end
                    res.evicted = 1'b1;
                    res.evicted_page = slot_page[fill_slot];
                end
                slot_valid[fill_slot] = 1'b1;
                slot_page[fill_slot] = pg;
                slot_frame[fill_slot] = res.frame;
                make_newest(fill_slot);
                res.outcome = OUT_FILL;
            end
        end
        res.hits = hit_cnt;
        res.misses = miss_cnt;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (eager || r < 40)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 12);
        end
        return $urandom_range(13, 60);
    endfunction

    function automatic logic [PAGE_W-1:0] pick_page();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return PAGE_W'($urandom_range(0, TABLE_PAGES - 1));
        end
        else if (r < 80)
        begin
            return PAGE_W'($urandom_range(TABLE_PAGES, 31));
        end
        return PAGE_W'($urandom());
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            return '0;
        end
        else if (r < 40)
        begin
            return '1;
        end
        return CFG_W'($urandom());
    endfunction

    task automatic send_page(input logic [PAGE_W-1:0] pg);
        xlat_result_t res;
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        page <= pg;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        res = translate_page(pg);
        pending_xlat.push_back(res);
        n_items++;
        case (res.outcome)
            OUT_TLB_HIT: n_hits++;
            OUT_FILL: n_fills++;
            default: n_faults++;
        endcase
        if (res.evicted)
        begin
            n_evictions++;
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_xlat.size() != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_FRAMES_LOW: pt_low = val;
            REG_FRAMES_HIGH: pt_high = val;
            REG_VALID_MASK: pt_mask = val[MASK_W-1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    // Reset table: a fill, a repeat hit, pages past the table and a second fill.
    task automatic test_default_table();
        send_page(20'd0);
        send_page(20'd0);
        send_page(20'd8);
        send_page(20'hFFFFF);
        send_page(20'd3);
    endtask

    // Extreme register values with every page unmapped; the unused index must not matter.
    task automatic test_register_writes();
        drain_results();
        write_reg(REG_FRAMES_LOW, 32'hFFFF_FFFF);
        write_reg(REG_FRAMES_HIGH, 32'h0000_0000);
        write_reg(REG_VALID_MASK, 32'hFFFF_FF00);
        write_reg(REG_UNUSED, 32'h5A5A_A5A5);
        send_page(20'd1);
        send_page(20'd5);
        send_page(20'd0);
    endtask

    // Only some pages mapped, so the lookups give a mix of fills and faults.
    task automatic test_partial_mask();
        drain_results();
        write_reg(REG_VALID_MASK, 32'h0000_00A6);
        send_page(20'd1);
        send_page(20'd2);
        send_page(20'd4);
        send_page(20'd5);
        send_page(20'd6);
    endtask

    // Fill the remaining free entries, then hit and miss on a full buffer.
    task automatic test_fill_to_full();
        drain_results();
        write_reg(REG_FRAMES_HIGH, 32'h8040_2010);
        write_reg(REG_VALID_MASK, 32'h0000_00FF);
        send_page(20'd4);
        send_page(20'd6);
        send_page(20'd7);
        send_page(20'd7);
        send_page(20'd0);
        send_page(20'd9);
        send_page(20'h80000);
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            eager = (phase == 1);
            write_reg(REG_FRAMES_LOW, pick_reg_value());
            write_reg(REG_FRAMES_HIGH, pick_reg_value());
            write_reg(REG_VALID_MASK, pick_reg_value());
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(REG_UNUSED, pick_reg_value());
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_page(pick_page());
            end
        end
        eager = 1'b0;
    endtask

    always @(posedge clk)
    begin
        xlat_result_t want;
        if (rst_n && done)
        begin
            if (pending_xlat.size() == 0)
            begin
                report_mismatch("result with no item pending", 32'(frame), 32'd0);
            end
            else
            begin
                want = pending_xlat.pop_front();
                n_checked++;
                if (frame !== want.frame)
                    report_mismatch("frame", 32'(frame), 32'(want.frame));
                if (outcome !== want.outcome)
                    report_mismatch("outcome", 32'(outcome), 32'(want.outcome));
                if (evicted !== want.evicted)
                    report_mismatch("evicted", 32'(evicted), 32'(want.evicted));
                if (evicted_page !== want.evicted_page)
                    report_mismatch("evicted_page", 32'(evicted_page),
                                    32'(want.evicted_page));
                if (hit_total !== want.hits)
                    report_mismatch("hit_total", hit_total, want.hits);
                if (miss_total !== want.misses)
                    report_mismatch("miss_total", miss_total, want.misses);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d cycles without progress", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_page[i] = '0;
            slot_frame[i] = '0;
            slot_age[i] = i;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_table();
        test_register_writes();
        test_partial_mask();
        test_fill_to_full();
        test_random_traffic();

        drain_results();
        repeat (4 * (SLOTS + 2)) @(posedge clk);

        $display("Translated %0d items and checked %0d results after %0d register writes.",
                 n_items, n_checked, n_writes);
        $display("Outcomes: %0d TLB hits, %0d fills (%0d with eviction), %0d page faults.",
                 n_hits, n_fills, n_evictions, n_faults);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tlbl_pkg.sv
rtl/tlbl_cell.sv
rtl/tlb_lru_translate_core.sv
verif/tlb_lru_translate_core_tb.sv
